FILE: design/tpm_pkg.sv
`timescale 1ns / 1ps

package tpm_pkg;

  // Byte address bits that reach the table store; the store holds one 32-bit
  // word per four bytes.
  localparam int unsigned STORE_ADDR_BITS = 18;
  localparam int unsigned WORD_BITS       = STORE_ADDR_BITS - 2;
  localparam int unsigned PAGE_WORD_BITS  = 10;

  localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;

  localparam logic [1:0] CFG_POOL_BOTTOM = 2'd0;
  localparam logic [1:0] CFG_POOL_TOP    = 2'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_CONFLICT   = 3'd2,
    ST_MAPPED     = 3'd3,
    ST_NO_PAGES   = 3'd4
  } tpm_status_e;

  typedef logic [WORD_BITS-1:0] word_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic        load_req;
    logic        rd_dir;
    logic        rd_leaf;
    logic        wr_super;
    logic        tbl_from_pde;
    logic        alloc;
    logic        clr_wr;
    logic        wr_link;
    logic        wr_leaf;
    logic        init_wr;
    logic        set_res;
    tpm_status_e res_code;
    logic        push_out;
  } tpm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic misaligned;
    logic op_super;
    logic rd_v;
    logic pde_rwx;
    logic pool_empty;
    logic clr_last;
    logic init_last;
    logic out_free;
  } tpm_stat_t;

endpackage

FILE: design/tpm_cfg_if.sv
`timescale 1ns / 1ps

interface tpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/tpm_req_if.sv
`timescale 1ns / 1ps

interface tpm_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] dir_base;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [9:0]  perm_flags;

  modport source (output valid, output op, output dir_base, output virt_addr,
                  output phys_addr, output perm_flags, input ready);
  modport sink (input valid, input op, input dir_base, input virt_addr,
                input phys_addr, input perm_flags, output ready);
endinterface

FILE: design/tpm_rsp_if.sv
`timescale 1ns / 1ps

interface tpm_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       flush_tlb;

  modport source (output valid, output status, output flush_tlb, input ready);
  modport sink (input valid, input status, input flush_tlb, output ready);
endinterface

FILE: design/two_level_page_table_mapper_top.sv
`timescale 1ns / 1ps

// Sv32 two-level page-table mapper. Each request beat on req installs one
// 4 KB leaf (op 0) or one 4 MB superpage (op 1) in an internal 64K-word table
// store addressed by physical byte address (bits above the store size alias).
// One response beat on rsp follows every request: status and flush_tlb, the
// latter set only for a successful write. Requests are handled one at a time:
// a misaligned request ends at the alignment check, a superpage after the
// directory read, and a 4 KB leaf after the directory and leaf reads; a 4 KB
// leaf that must allocate a fresh page table first clears that page through
// the single store write port, one word per cycle. After reset the block runs
// a clearing pass over the whole store with req.ready low; cfg writes are
// taken throughout (cfg.ready is always high). Register 0 is pool_bottom,
// register 1 is pool_top and also reloads the allocation pointer; other
// indexes drop. Write configuration only while no request is in flight.

module two_level_page_table_mapper_top
  import tpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tpm_cfg_if.sink   cfg,
  tpm_req_if.sink   req,
  tpm_rsp_if.source rsp
);

  tpm_cmd_t  cmd;
  tpm_stat_t stat;
  logic      in_ready;

  // Config beats never stall
  assign cfg.ready = 1'b1;
  assign req.ready = in_ready;

  // Sequencer: walks the directory, allocation, clear and leaf steps
  tpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: table store, request registers, pool pointer, output register
  tpm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_valid_i  (cfg.valid),
    .cfg_index_i  (cfg.index),
    .cfg_data_i   (cfg.data),
    .op_i         (req.op),
    .dir_base_i   (req.dir_base),
    .virt_addr_i  (req.virt_addr),
    .phys_addr_i  (req.phys_addr),
    .perm_flags_i (req.perm_flags),
    .out_valid_o  (rsp.valid),
    .out_ready_i  (rsp.ready),
    .status_o     (rsp.status),
    .flush_tlb_o  (rsp.flush_tlb)
  );

endmodule

FILE: design/tpm_dp.sv
`timescale 1ns / 1ps

module tpm_dp
  import tpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tpm_cmd_t    cmd_i,
  output tpm_stat_t   stat_o,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        op_i,
  input  logic [31:0] dir_base_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [9:0]  perm_flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        flush_tlb_o
);

  logic [31:0] store_q [2**WORD_BITS];
  logic [31:0] rd_data_q;

  logic        op_q;
  logic [31:0] dir_q, va_q, pa_q;
  logic [9:0]  flags_q;

  logic [31:0] pool_bottom_q, alloc_q, tbl_q;
  logic [PAGE_WORD_BITS-1:0] clr_cnt_q;
  word_idx_t   init_cnt_q;

  tpm_status_e res_q;
  logic        out_valid_q;
  tpm_status_e out_status_q;

  logic [31:0] dir_byte, leaf_byte, new_alloc;
  word_idx_t   dir_word, leaf_word, clr_word;
  logic        wr_en, rd_en;
  word_idx_t   wr_addr, rd_addr;
  logic [31:0] wr_data;

  assign dir_byte  = dir_q + {20'b0, va_q[31:22], 2'b00};
  assign leaf_byte = tbl_q + {20'b0, va_q[21:12], 2'b00};
  assign dir_word  = dir_byte[STORE_ADDR_BITS-1:2];
  assign leaf_word = leaf_byte[STORE_ADDR_BITS-1:2];
  assign clr_word  = tbl_q[STORE_ADDR_BITS-1:2]
                   + {{(WORD_BITS-PAGE_WORD_BITS){1'b0}}, clr_cnt_q};
  assign new_alloc = alloc_q - PAGE_BYTES;

  // Store port select: at most one write and one read per cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dir_word;
    wr_data = 32'b0;
    if (cmd_i.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = init_cnt_q;
    end else if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_word;
    end else if (cmd_i.wr_link) begin
      wr_en   = 1'b1;
      wr_data = {2'b00, tbl_q[31:2]} | 32'd1;
    end else if (cmd_i.wr_super) begin
      wr_en   = 1'b1;
      wr_data = {2'b00, pa_q[31:12], flags_q};
    end else if (cmd_i.wr_leaf) begin
      wr_en   = 1'b1;
      wr_addr = leaf_word;
      wr_data = {2'b00, pa_q[31:12], flags_q};
    end
  end

  assign rd_en   = cmd_i.rd_dir | cmd_i.rd_leaf;
  assign rd_addr = cmd_i.rd_leaf ? leaf_word : dir_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  // Request payload, table pointer, result code and output status
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q    <= op_i;
      dir_q   <= dir_base_i;
      va_q    <= virt_addr_i;
      pa_q    <= phys_addr_i;
      flags_q <= perm_flags_i;
    end
    if (cmd_i.tbl_from_pde) begin
      tbl_q <= {rd_data_q[29:10], 12'b0};
    end else if (cmd_i.alloc) begin
      tbl_q <= new_alloc;
    end
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res_code;
    end
    if (cmd_i.push_out) begin
      out_status_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_bottom_q <= 32'b0;
      alloc_q       <= 32'b0;
      clr_cnt_q     <= '0;
      init_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_POOL_BOTTOM) begin
        pool_bottom_q <= cfg_data_i;
      end
      // Writing the pool top reloads the allocation pointer
      if (cfg_valid_i && cfg_index_i == CFG_POOL_TOP) begin
        alloc_q <= cfg_data_i;
      end else if (cmd_i.alloc) begin
        alloc_q <= new_alloc;
      end
      if (cmd_i.alloc) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.init_wr) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (cmd_i.push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.misaligned = op_q ? ((|va_q[21:0]) || (|pa_q[21:0]))
                             : ((|va_q[11:0]) || (|pa_q[11:0]));
    stat_o.op_super   = op_q;
    stat_o.rd_v       = rd_data_q[0];
    stat_o.pde_rwx    = |rd_data_q[3:1];
    stat_o.pool_empty = {1'b0, alloc_q} < ({1'b0, pool_bottom_q} + {1'b0, PAGE_BYTES});
    stat_o.clr_last   = &clr_cnt_q;
    stat_o.init_last  = &init_cnt_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign flush_tlb_o = (out_status_q == ST_OK);

endmodule

FILE: design/tpm_ctrl.sv
`timescale 1ns / 1ps

module tpm_ctrl
  import tpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tpm_stat_t stat_i,
  output tpm_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_PDE_CHK,
    S_CLEAR,
    S_LINK,
    S_LEAF_RD,
    S_LEAF_CHK,
    S_DONE
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_code = ST_OK;
    state_d        = state_q;
    in_ready_o     = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.rd_dir = 1'b1;
        if (stat_i.misaligned) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_MISALIGNED;
          state_d        = S_DONE;
        end else begin
          state_d = S_PDE_CHK;
        end
      end
      S_PDE_CHK: begin
        if (stat_i.op_super) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
          if (stat_i.rd_v) begin
            cmd_o.res_code = ST_CONFLICT;
          end else begin
            cmd_o.wr_super = 1'b1;
            cmd_o.res_code = ST_OK;
          end
        end else if (stat_i.rd_v) begin
          if (stat_i.pde_rwx) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = ST_CONFLICT;
            state_d        = S_DONE;
          end else begin
            cmd_o.tbl_from_pde = 1'b1;
            state_d            = S_LEAF_RD;
          end
        end else if (stat_i.pool_empty) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_NO_PAGES;
          state_d        = S_DONE;
        end else begin
          cmd_o.alloc = 1'b1;
          state_d     = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.wr_link = 1'b1;
        state_d       = S_LEAF_RD;
      end
      S_LEAF_RD: begin
        cmd_o.rd_leaf = 1'b1;
        state_d       = S_LEAF_CHK;
      end
      S_LEAF_CHK: begin
        cmd_o.set_res = 1'b1;
        state_d       = S_DONE;
        if (stat_i.rd_v) begin
          cmd_o.res_code = ST_MAPPED;
        end else begin
          cmd_o.wr_leaf  = 1'b1;
          cmd_o.res_code = ST_OK;
        end
      end
      S_DONE: begin
        // Hold until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
